### sv/oxab_pkg.sv
package oxab_pkg;

  localparam int PCT_W   = 7;
  localparam int DRV_W   = 10;
  localparam int NUM_W   = PCT_W + DRV_W;
  localparam int CFG_IDX_W = 3;

  // quotient is below the drive span, so DRV_W bits of it are enough
  localparam int QUO_W          = DRV_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / STEPS_PER_STAGE;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_AIR  = 7'd21;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_UP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OXY_UP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OXY_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd6;

  localparam logic [DRV_W-1:0] CEILING_RST = 10'd483;
  localparam logic [DRV_W-1:0] FLOOR_RST   = 10'd60;

  // one interpolation job for a lane
  typedef struct packed {
    logic             valid;
    logic             use_lerp;
    logic [DRV_W-1:0] fixed_val;
    logic [DRV_W-1:0] a;
    logic             neg;
    logic [DRV_W-1:0] mag;
    logic [PCT_W-1:0] dx;
    logic [PCT_W-1:0] den;
  } lerp_req_t;

  typedef struct packed {
    logic             valid;
    logic [DRV_W-1:0] value;
  } lerp_rsp_t;

  // state of one divider stage
  typedef struct packed {
    logic             valid;
    logic             use_lerp;
    logic [DRV_W-1:0] fixed_val;
    logic [DRV_W-1:0] a;
    logic             neg;
    logic [PCT_W-1:0] den;
    logic [PCT_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
  } div_st_t;

endpackage

### sv/oxygen_air_blend_valve_pwm_top.sv
// Oxygen/air blend valve drive. A transfer on start (with busy, which stays low) hands in a
// target oxygen percent; done later goes high for one cycle with the air and oxygen drive
// values on air_drive and oxygen_drive. A new target can be given in every cycle and results
// come out in order, one per target; the receiver cannot stall them, so it must take each
// result in its done cycle. The path is an input register, a decode stage and a 7x10
// multiply stage, five two-bit restoring divider stages and an output stage. Configuration
// is written through cfg_we/cfg_index/cfg_data, by the user only while no target is in
// flight, which the block does not enforce. An index past the last register is ignored.
module oxygen_air_blend_valve_pwm_top (
  input  logic                                clk,
  input  logic                                rst,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic [oxab_pkg::PCT_W-1:0]          target_percent,
  // result side
  output logic                                done,
  output logic [oxab_pkg::DRV_W-1:0]          air_drive,
  output logic [oxab_pkg::DRV_W-1:0]          oxygen_drive,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [oxab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oxab_pkg::DRV_W-1:0]          cfg_data
);

  // accept to done, in cycles
  localparam int LATENCY = oxab_pkg::DIV_STAGES + 4;

  // configuration registers
  logic [oxab_pkg::PCT_W-1:0] switch_percent;
  logic [oxab_pkg::DRV_W-1:0] air_upper;
  logic [oxab_pkg::DRV_W-1:0] air_lower;
  logic [oxab_pkg::DRV_W-1:0] oxygen_upper;
  logic [oxab_pkg::DRV_W-1:0] oxygen_lower;
  logic [oxab_pkg::DRV_W-1:0] drive_ceiling;
  logic [oxab_pkg::DRV_W-1:0] drive_floor;

  // input register
  logic                       tgt_valid;
  logic [oxab_pkg::PCT_W-1:0] tgt;

  // decode stage, one job per valve
  oxab_pkg::lerp_req_t air_req;
  oxab_pkg::lerp_req_t air_req_next;
  oxab_pkg::lerp_req_t oxy_req;
  oxab_pkg::lerp_req_t oxy_req_next;
  oxab_pkg::lerp_rsp_t air_rsp;
  oxab_pkg::lerp_rsp_t oxy_rsp;

  // the pipeline never holds off a new target
  assign busy = 1'b0;

  // register writes, unknown index dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_percent <= '0;
      air_upper      <= '0;
      air_lower      <= '0;
      oxygen_upper   <= '0;
      oxygen_lower   <= '0;
      drive_ceiling  <= oxab_pkg::CEILING_RST;
      drive_floor    <= oxab_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        oxab_pkg::REG_SWITCH:  switch_percent <= cfg_data[oxab_pkg::PCT_W-1:0];
        oxab_pkg::REG_AIR_UP:  air_upper      <= cfg_data;
        oxab_pkg::REG_AIR_LO:  air_lower      <= cfg_data;
        oxab_pkg::REG_OXY_UP:  oxygen_upper   <= cfg_data;
        oxab_pkg::REG_OXY_LO:  oxygen_lower   <= cfg_data;
        oxab_pkg::REG_CEILING: drive_ceiling  <= cfg_data;
        oxab_pkg::REG_FLOOR:   drive_floor    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: target sampled every cycle, valid set by a start transfer
  always_ff @(posedge clk) begin
    tgt <= target_percent;
    if (rst) begin
      tgt_valid <= 1'b0;
    end else begin
      tgt_valid <= start && !busy;
    end
  end

  // air curve: ceiling up to the switch point, floor at or past full oxygen,
  // otherwise interpolate from air_upper toward air_lower
  always_comb begin
    air_req_next.valid     = tgt_valid;
    air_req_next.a         = air_upper;
    air_req_next.neg       = air_lower < air_upper;
    air_req_next.mag       = air_req_next.neg ? (air_upper - air_lower)
                                              : (air_lower - air_upper);
    air_req_next.dx        = tgt - switch_percent;
    air_req_next.den       = oxab_pkg::PCT_FULL - switch_percent;
    air_req_next.use_lerp  = 1'b0;
    air_req_next.fixed_val = drive_ceiling;
    if (tgt <= switch_percent) begin
      air_req_next.fixed_val = drive_ceiling;
    end else if (tgt >= oxab_pkg::PCT_FULL) begin
      air_req_next.fixed_val = drive_floor;
    end else begin
      air_req_next.use_lerp  = 1'b1;
    end
  end

  // oxygen curve: floor at or below room air, interpolate from oxygen_lower
  // toward oxygen_upper below the switch point, ceiling from there on
  always_comb begin
    oxy_req_next.valid     = tgt_valid;
    oxy_req_next.a         = oxygen_lower;
    oxy_req_next.neg       = oxygen_upper < oxygen_lower;
    oxy_req_next.mag       = oxy_req_next.neg ? (oxygen_lower - oxygen_upper)
                                              : (oxygen_upper - oxygen_lower);
    oxy_req_next.dx        = tgt - oxab_pkg::PCT_AIR;
    oxy_req_next.den       = switch_percent - oxab_pkg::PCT_AIR;
    oxy_req_next.use_lerp  = 1'b0;
    oxy_req_next.fixed_val = drive_ceiling;
    if (tgt < switch_percent) begin
      if (tgt <= oxab_pkg::PCT_AIR) begin
        oxy_req_next.fixed_val = drive_floor;
      end else begin
        oxy_req_next.use_lerp  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      air_req <= '0;
      oxy_req <= '0;
    end else begin
      air_req <= air_req_next;
      oxy_req <= oxy_req_next;
    end
  end

  // multiply, divide and round lanes
  oxab_lerp u_air_lerp (
    .clk (clk),
    .rst (rst),
    .req (air_req),
    .rsp (air_rsp)
  );

  oxab_lerp u_oxy_lerp (
    .clk (clk),
    .rst (rst),
    .req (oxy_req),
    .rsp (oxy_rsp)
  );

  // results leave straight from the lane output registers
  assign done         = air_rsp.valid;
  assign air_drive    = air_rsp.value;
  assign oxygen_drive = oxy_rsp.value;

  // both lanes must stay in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    air_rsp.valid == oxy_rsp.valid)
    else $error("air and oxygen lanes out of step");

  // every result traces back to an earlier start transfer
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching start transfer");

  // an accepted target in the input register always reaches the decode stage of both lanes
  a_start_yields: assert property (@(posedge clk) disable iff (rst)
    tgt_valid |=> air_req.valid && oxy_req.valid)
    else $error("accepted target dropped at decode stage");

endmodule

### sv/oxab_lerp.sv
module oxab_lerp (
  input  logic                clk,
  input  logic                rst,
  input  oxab_pkg::lerp_req_t req,
  output oxab_pkg::lerp_rsp_t rsp
);

  // one restoring step: bring down a numerator bit, subtract if it fits
  function automatic oxab_pkg::div_st_t div_step(input oxab_pkg::div_st_t s);
    oxab_pkg::div_st_t r;
    logic [oxab_pkg::PCT_W:0] trial;
    logic                     fits;
    r     = s;
    trial = {s.rem, s.low[oxab_pkg::QUO_W-1]};
    fits  = (trial >= {1'b0, s.den});
    if (fits) begin
      r.rem = oxab_pkg::PCT_W'(trial - {1'b0, s.den});
    end else begin
      r.rem = trial[oxab_pkg::PCT_W-1:0];
    end
    r.low = {s.low[oxab_pkg::QUO_W-2:0], 1'b0};
    r.quo = {s.quo[oxab_pkg::QUO_W-2:0], fits};
    return r;
  endfunction

  oxab_pkg::div_st_t                 mul;
  oxab_pkg::div_st_t                 mul_next;
  oxab_pkg::div_st_t                 stg [oxab_pkg::DIV_STAGES];
  oxab_pkg::div_st_t                 stg_next [oxab_pkg::DIV_STAGES];
  logic [oxab_pkg::NUM_W-1:0]        prod;
  logic [oxab_pkg::DRV_W:0]          sum;
  oxab_pkg::div_st_t                 last;

  // multiply stage: numerator split into leading remainder and low bits
  always_comb begin
    prod               = oxab_pkg::NUM_W'(req.dx) * oxab_pkg::NUM_W'(req.mag);
    mul_next.valid     = req.valid;
    mul_next.use_lerp  = req.use_lerp;
    mul_next.fixed_val = req.fixed_val;
    mul_next.a         = req.a;
    mul_next.neg       = req.neg;
    mul_next.den       = req.den;
    mul_next.rem       = prod[oxab_pkg::NUM_W-1:oxab_pkg::QUO_W];
    mul_next.low       = prod[oxab_pkg::QUO_W-1:0];
    mul_next.quo       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul <= '0;
    end else begin
      mul <= mul_next;
    end
  end

  for (genvar k = 0; k < oxab_pkg::DIV_STAGES; k++) begin : g_div
    always_comb begin
      oxab_pkg::div_st_t cur;
      cur = (k == 0) ? mul : stg[(k == 0) ? 0 : k-1];
      for (int j = 0; j < oxab_pkg::STEPS_PER_STAGE; j++) begin
        cur = div_step(cur);
      end
      stg_next[k] = cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k] <= '0;
      end else begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // floor toward minus infinity when the span goes down
  assign last = stg[oxab_pkg::DIV_STAGES-1];

  always_comb begin
    if (last.neg) begin
      sum = {1'b0, last.a} - {1'b0, last.quo}
            - (oxab_pkg::DRV_W+1)'(last.rem != '0);
    end else begin
      sum = {1'b0, last.a} + {1'b0, last.quo};
    end
  end

  always_ff @(posedge clk) begin
    rsp.value <= last.use_lerp ? sum[oxab_pkg::DRV_W-1:0] : last.fixed_val;
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= last.valid;
    end
  end

endmodule
